>>> rtl/ata_pio_sector_sequencer_unit_defines.svh
// Assertion macros for the ATA PIO sector sequencer checker.
// Used by ata_pio_sector_sequencer_unit_checker.sv; no other dependency.
`ifndef ATA_PIO_SECTOR_SEQUENCER_UNIT_DEFINES_SVH
`define ATA_PIO_SECTOR_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define APS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ata pio sequencer assertion failed");

// next-cycle implication
`define APS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ata pio sequencer assertion failed");

`endif

>>> rtl/aps_pkg.sv
// Package for the ATA PIO sector sequencer: access kinds, completion codes, actions,
// config indices, register selects, command values and the result item type. No dependencies.
package aps_pkg;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_WR   = 3'd1;
    localparam logic [2:0] KIND_RD   = 3'd2;
    localparam logic [2:0] KIND_RDX  = 3'd3;
    localparam logic [2:0] KIND_SIN  = 3'd4;
    localparam logic [2:0] KIND_SOUT = 3'd5;

    localparam logic [2:0] DONE_RUN     = 3'd0;
    localparam logic [2:0] DONE_OK      = 3'd1;
    localparam logic [2:0] DONE_INVALID = 3'd2;
    localparam logic [2:0] DONE_UNSUP   = 3'd3;
    localparam logic [2:0] DONE_TIMEOUT = 3'd4;
    localparam logic [2:0] DONE_ERROR   = 3'd5;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    localparam logic [1:0] CFG_DEVICE_SECTORS = 2'd0;
    localparam logic [1:0] CFG_DRIVE_SELECT   = 2'd1;
    localparam logic [1:0] CFG_BUSY_LIMIT     = 2'd2;
    localparam logic [1:0] CFG_DRQ_LIMIT      = 2'd3;

    localparam logic [3:0] TF_DATA     = 4'd0;
    localparam logic [3:0] TF_COUNT    = 4'd2;
    localparam logic [3:0] TF_LBA_LOW  = 4'd3;
    localparam logic [3:0] TF_LBA_MID  = 4'd4;
    localparam logic [3:0] TF_LBA_HIGH = 4'd5;
    localparam logic [3:0] TF_DEVSEL   = 4'd6;
    localparam logic [3:0] TF_STATUS   = 4'd7;
    localparam logic [3:0] TF_ALT      = 4'd8;

    localparam logic [7:0] DEV_BASE  = 8'hE0;
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] ST_ZERO   = 8'h00;
    localparam logic [7:0] ST_FLOAT  = 8'hFF;

    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] sel;
        logic [7:0] value;
        logic [2:0] code;
    } res_t;

endpackage

>>> rtl/ata_pio_sector_sequencer_unit.sv
// ATA PIO LBA28 sector sequencer: one input item yields up to seven result items.
// The first result appears in the cycle after the item is accepted; then one result
// per cycle while out_stall is low. The next item is taken in the cycle the last
// result of the previous one leaves; until then in_stall holds new items off.
// Reset: rst_n asynchronous, low; sequencer idle, registers at their reset values.
module ata_pio_sector_sequencer_unit #(
    parameter int CHUNK_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] start_sector,
    input  logic [31:0] sector_count,
    input  logic [7:0]  status_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  access_kind,
    output logic [3:0]  reg_select,
    output logic [7:0]  write_value,
    output logic [2:0]  done_code,
    output logic        last
);
    import aps_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_BUSY_PRE = 3'd1;
    localparam logic [2:0] PH_DRQ      = 3'd2;
    localparam logic [2:0] PH_DRQ_FB   = 3'd3;
    localparam logic [2:0] PH_BUSY_TL  = 3'd4;
    localparam logic [7:0] CHUNK_LIM   = 8'(CHUNK_MAX);

    logic [31:0] dev_sectors_reg;
    logic        drive_sel_reg;
    logic [15:0] busy_limit_reg;
    logic [15:0] drq_limit_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] lba_reg, lba_next;
    logic [31:0] left_reg, left_next;
    logic [7:0]  csize_reg, csize_next;
    logic [7:0]  cleft_reg, cleft_next;
    logic [15:0] budget_reg, budget_next;
    logic        wmode_reg, wmode_next;

    res_t        buf_reg [MAX_RESULTS];
    res_t        buf_next [MAX_RESULTS];
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  idx_reg;
    logic        busy_reg;

    logic        take, is_last, accept;
    logic        bad, bsy, drq, err;
    logic [64:0] range_end;
    logic [7:0]  sel_base;

    assign cfg_ready = 1'b1;
    assign take      = busy_reg && !out_stall;
    assign is_last   = ({1'b0, idx_reg} == cnt_reg - 4'd1);
    assign in_stall  = busy_reg && !(take && is_last);
    assign accept    = in_valid && !in_stall;

    assign out_valid   = busy_reg;
    assign access_kind = buf_reg[idx_reg].kind;
    assign reg_select  = buf_reg[idx_reg].sel;
    assign write_value = buf_reg[idx_reg].value;
    assign done_code   = buf_reg[idx_reg].code;
    assign last        = is_last;

    assign bad       = (status_value == ST_ZERO) || (status_value == ST_FLOAT);
    assign bsy       = status_value[7];
    assign drq       = status_value[3];
    assign err       = status_value[0];
    assign range_end = {1'b0, start_sector} + {33'd0, sector_count};
    assign sel_base  = DEV_BASE | {3'd0, drive_sel_reg, 4'd0};

    always_comb
    begin
        logic       fin, sm, nof, bc, iss, sd, sbt;
        logic [2:0] fcode;
        logic [3:0] n;

        phase_next  = phase_reg;
        lba_next    = lba_reg;
        left_next   = left_reg;
        csize_next  = csize_reg;
        cleft_next  = cleft_reg;
        budget_next = budget_reg;
        wmode_next  = wmode_reg;
        fin = 1'b0; sm = 1'b0; nof = 1'b0; bc = 1'b0; iss = 1'b0; sd = 1'b0; sbt = 1'b0;
        fcode = DONE_RUN;
        n = 4'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            buf_next[i] = '0;
        end

        if ((action == ACT_READ || action == ACT_WRITE) && phase_reg == PH_IDLE)
        begin
            wmode_next = action[0];
            if (sector_count == 32'd0)
            begin
                fin = 1'b1; fcode = DONE_OK;
            end
            else if (range_end > {33'd0, dev_sectors_reg})
            begin
                fin = 1'b1; fcode = DONE_INVALID;
            end
            else if (start_sector[63:28] != 36'd0)
            begin
                fin = 1'b1; fcode = DONE_UNSUP;
            end
            else
            begin
                lba_next  = start_sector[31:0];
                left_next = sector_count;
                bc = 1'b1;
            end
        end
        else if (action == ACT_STATUS)
        begin
            case (phase_reg)
                PH_BUSY_PRE, PH_BUSY_TL:
                begin
                    if (bad)
                    begin
                        fin = 1'b1; fcode = DONE_TIMEOUT;
                    end
                    else if (!bsy)
                    begin
                        if (phase_reg == PH_BUSY_PRE) iss = 1'b1;
                        else nof = 1'b1;
                    end
                    else
                    begin
                        budget_next = budget_reg - 16'd1;
                        if (budget_next == 16'd0)
                        begin
                            fin = 1'b1; fcode = DONE_TIMEOUT;
                        end
                        else
                        begin
                            buf_next[n[2:0]] = '{KIND_RD,
                                (phase_reg == PH_BUSY_PRE && wmode_reg) ? TF_ALT : TF_STATUS,
                                8'd0, DONE_RUN};
                            n = n + 4'd1;
                        end
                    end
                end
                PH_DRQ:
                begin
                    if (bad || err)
                    begin
                        fin = 1'b1; fcode = DONE_ERROR;
                    end
                    else if (!bsy && drq)
                    begin
                        sm = 1'b1;
                    end
                    else
                    begin
                        budget_next = budget_reg - 16'd1;
                        if (budget_next == 16'd0)
                        begin
                            if (wmode_reg)
                            begin
                                fin = 1'b1; fcode = DONE_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_DRQ_FB;
                                buf_next[n[2:0]] = '{KIND_RD, TF_STATUS, 8'd0, DONE_RUN};
                                n = n + 4'd1;
                            end
                        end
                        else
                        begin
                            buf_next[n[2:0]] = '{KIND_RD, wmode_reg ? TF_STATUS : TF_ALT,
                                8'd0, DONE_RUN};
                            n = n + 4'd1;
                        end
                    end
                end
                PH_DRQ_FB:
                begin
                    if (!bsy && drq && !err) sm = 1'b1;
                    else
                    begin
                        fin = 1'b1; fcode = DONE_ERROR;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (sm)
        begin
            if (wmode_reg)
            begin
                buf_next[n[2:0]] = '{KIND_SOUT, TF_DATA, 8'd0, DONE_RUN};
                n = n + 4'd1;
                buf_next[n[2:0]] = '{KIND_RDX, TF_STATUS, 8'd0, DONE_RUN};
                n = n + 4'd1;
            end
            else
            begin
                buf_next[n[2:0]] = '{KIND_SIN, TF_DATA, 8'd0, DONE_RUN};
                n = n + 4'd1;
            end
            cleft_next = cleft_reg - 8'd1;
            lba_next   = lba_reg + 32'd1;
            left_next  = left_reg - 32'd1;
            if (cleft_next != 8'd0) sd = 1'b1;
            else if (wmode_reg) sbt = 1'b1;
            else nof = 1'b1;
        end

        if (nof)
        begin
            if (left_next == 32'd0)
            begin
                fin = 1'b1; fcode = DONE_OK;
            end
            else bc = 1'b1;
        end

        if (bc)
        begin
            csize_next = (left_next > {24'd0, CHUNK_LIM}) ? CHUNK_LIM : left_next[7:0];
            cleft_next = csize_next;
            buf_next[n[2:0]] = '{KIND_WR, TF_DEVSEL, sel_base, DONE_RUN};
            n = n + 4'd1;
            for (int i = 0; i < 4; i++)
            begin
                buf_next[n[2:0]] = '{KIND_RDX, TF_ALT, 8'd0, DONE_RUN};
                n = n + 4'd1;
            end
            phase_next  = PH_BUSY_PRE;
            budget_next = busy_limit_reg;
            if (busy_limit_reg == 16'd0)
            begin
                fin = 1'b1; fcode = DONE_TIMEOUT;
            end
            else
            begin
                buf_next[n[2:0]] = '{KIND_RD, wmode_next ? TF_ALT : TF_STATUS,
                    8'd0, DONE_RUN};
                n = n + 4'd1;
            end
        end

        if (iss)
        begin
            buf_next[n[2:0]] = '{KIND_WR, TF_DEVSEL, sel_base | {4'd0, lba_reg[27:24]},
                DONE_RUN};
            n = n + 4'd1;
            buf_next[n[2:0]] = '{KIND_WR, TF_COUNT, csize_reg, DONE_RUN};
            n = n + 4'd1;
            buf_next[n[2:0]] = '{KIND_WR, TF_LBA_LOW, lba_reg[7:0], DONE_RUN};
            n = n + 4'd1;
            buf_next[n[2:0]] = '{KIND_WR, TF_LBA_MID, lba_reg[15:8], DONE_RUN};
            n = n + 4'd1;
            buf_next[n[2:0]] = '{KIND_WR, TF_LBA_HIGH, lba_reg[23:16], DONE_RUN};
            n = n + 4'd1;
            buf_next[n[2:0]] = '{KIND_WR, TF_STATUS, wmode_reg ? CMD_WRITE : CMD_READ,
                DONE_RUN};
            n = n + 4'd1;
            sd = 1'b1;
        end

        if (sd)
        begin
            budget_next = drq_limit_reg;
            if (drq_limit_reg == 16'd0)
            begin
                if (wmode_reg)
                begin
                    fin = 1'b1; fcode = DONE_ERROR;
                end
                else
                begin
                    phase_next = PH_DRQ_FB;
                    buf_next[n[2:0]] = '{KIND_RD, TF_STATUS, 8'd0, DONE_RUN};
                    n = n + 4'd1;
                end
            end
            else
            begin
                phase_next = PH_DRQ;
                buf_next[n[2:0]] = '{KIND_RD, wmode_reg ? TF_STATUS : TF_ALT,
                    8'd0, DONE_RUN};
                n = n + 4'd1;
            end
        end

        if (sbt)
        begin
            phase_next  = PH_BUSY_TL;
            budget_next = busy_limit_reg;
            if (busy_limit_reg == 16'd0)
            begin
                fin = 1'b1; fcode = DONE_TIMEOUT;
            end
            else
            begin
                buf_next[n[2:0]] = '{KIND_RD, TF_STATUS, 8'd0, DONE_RUN};
                n = n + 4'd1;
            end
        end

        if (fin)
        begin
            buf_next[n[2:0]] = '{KIND_NONE, TF_DATA, 8'd0, fcode};
            n = n + 4'd1;
            phase_next = PH_IDLE;
        end

        cnt_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_sectors_reg <= 32'd0;
            drive_sel_reg   <= 1'b0;
            busy_limit_reg  <= 16'd20000;
            drq_limit_reg   <= 16'd60000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_SECTORS: dev_sectors_reg <= cfg_data;
                CFG_DRIVE_SELECT:   drive_sel_reg   <= cfg_data[0];
                CFG_BUSY_LIMIT:     busy_limit_reg  <= cfg_data[15:0];
                CFG_DRQ_LIMIT:      drq_limit_reg   <= cfg_data[15:0];
                default:            drive_sel_reg   <= drive_sel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            lba_reg    <= 32'd0;
            left_reg   <= 32'd0;
            csize_reg  <= 8'd0;
            cleft_reg  <= 8'd0;
            budget_reg <= 16'd0;
            wmode_reg  <= 1'b0;
            busy_reg   <= 1'b0;
            idx_reg    <= 3'd0;
            cnt_reg    <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            lba_reg    <= lba_next;
            left_reg   <= left_next;
            csize_reg  <= csize_next;
            cleft_reg  <= cleft_next;
            budget_reg <= budget_next;
            wmode_reg  <= wmode_next;
            busy_reg   <= (cnt_next != 4'd0);
            idx_reg    <= 3'd0;
            cnt_reg    <= cnt_next;
        end
        else if (take)
        begin
            if (is_last) busy_reg <= 1'b0;
            else idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

endmodule

>>> rtl/ata_pio_sector_sequencer_unit_checker.sv
// Port-level checker for the ATA PIO sector sequencer, bound to the top level.
// Depends on aps_pkg and ata_pio_sector_sequencer_unit_defines.svh.
`include "ata_pio_sector_sequencer_unit_defines.svh"

module ata_pio_sector_sequencer_unit_props (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] access_kind,
    input logic [2:0] done_code,
    input logic       last
);
    import aps_pkg::*;

    `APS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(access_kind) && $stable(done_code) && $stable(last))
    `APS_ASSERT_IMPL(a_done_is_last, out_valid && done_code != DONE_RUN, last)
    `APS_ASSERT_IMPL(a_none_has_code, out_valid && access_kind == KIND_NONE, done_code != DONE_RUN)

endmodule

bind ata_pio_sector_sequencer_unit ata_pio_sector_sequencer_unit_props u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .access_kind (access_kind),
    .done_code   (done_code),
    .last        (last)
);
